// File: rtl/zbh_pkg.sv
//------------------------------------------------------------------------------
// zbh_pkg
// Shared constants and types for the Zobrist board hash: key table layout,
// generator constants, sequencer states and the key write request.
//------------------------------------------------------------------------------
`default_nettype none

package zbh_pkg;

  // Key table layout
  localparam int KEY_COUNT = 781;
  localparam int KEY_AW    = 10;
  localparam int WHITE_KEY = 768;
  localparam int KSIDE_KEY = 769;
  localparam int QSIDE_KEY = 771;
  localparam int EP_KEY    = 773;
  localparam int KIND_COUNT = 6;

  // Header key slots, in the order of the pending mask
  localparam logic [2:0] HDR_WHITE = 3'd0;
  localparam logic [2:0] HDR_EP    = 3'd1;
  localparam logic [2:0] HDR_BK    = 3'd2;
  localparam logic [2:0] HDR_WK    = 3'd3;
  localparam logic [2:0] HDR_BQ    = 3'd4;
  localparam logic [2:0] HDR_WQ    = 3'd5;

  // 64-bit Mersenne twister
  localparam int          MT_N      = 312;
  localparam int          MT_M      = 156;
  localparam int          MT_AW     = 9;
  localparam logic [63:0] MT_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] MT_UPPER  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MT_LOWER  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MT_MULT   = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] MT_TMASK_B = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] MT_TMASK_C = 64'hFFF7_EEE0_0000_0000;
  localparam logic [63:0] MT_TMASK_A = 64'h5555_5555_5555_5555;

  // Key generator sequencer
  typedef enum logic [2:0] {
    KG_SEED0,
    KG_SEED,
    KG_TWIST,
    KG_GEN,
    KG_DONE
  } kg_state_t;

  // Hash sequencer
  typedef enum logic {
    HS_IDLE,
    HS_RUN
  } hs_state_t;

  // Key table write request
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic [63:0]       data;
  } key_wr_t;

endpackage

`default_nettype wire

// File: rtl/zbh_if.sv
//------------------------------------------------------------------------------
// zbh_if
// Valid/ready channels of the board hash: position items in, hashes out.
//------------------------------------------------------------------------------
`default_nettype none

interface zbh_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        white_to_move;
  logic [3:0]  castle_rights;
  logic        ep_valid;
  logic [5:0]  ep_square;
  logic        piece_color;
  logic [2:0]  piece_kind;
  logic [63:0] piece_bitboard;
  logic        last;

  modport source (
    output valid, mode, white_to_move, castle_rights, ep_valid, ep_square,
           piece_color, piece_kind, piece_bitboard, last,
    input  ready
  );
  modport sink (
    input  valid, mode, white_to_move, castle_rights, ep_valid, ep_square,
           piece_color, piece_kind, piece_bitboard, last,
    output ready
  );
endinterface

interface zbh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

`default_nettype wire

// File: rtl/zobrist_board_hash.sv
//------------------------------------------------------------------------------
// zobrist_board_hash
// 64-bit Zobrist hash of a chess position delivered as a run of items.
//------------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   mode, header fields, piece fields, last
//  out_ch   out  valid/ready   hash_value (one per item marked last)
//
//  After reset the key table is filled by the on-chip generator with in_ch.ready
//  low: it seeds its state word by word, then runs 3 twists, each followed by
//  key output; its state reads share the single read port of its memory.
//  An item needs one key table read per set bit of the bitboard (or per header
//  key) after it is accepted, then the last read is folded in; a new item is
//  taken only when the sequencer is idle again.
//  A held hash does not block the next item; a later hash waits for the slot.
//------------------------------------------------------------------------------
`default_nettype none

module zobrist_board_hash (
  input  logic      clk,
  input  logic      rst_n,
  zbh_in_if.sink    in_ch,
  zbh_out_if.source out_ch
);
  import zbh_pkg::*;

  key_wr_t           key_wr;
  logic              keys_done;
  logic [KEY_AW-1:0] rom_raddr;
  logic [63:0]       rom_rdata;

  zbh_keygen u_keygen (
    .clk         (clk),
    .rst_n       (rst_n),
    .key_wr_o    (key_wr),
    .keys_done_o (keys_done)
  );

  zbh_key_rom u_key_rom (
    .clk      (clk),
    .key_wr_i (key_wr),
    .raddr_i  (rom_raddr),
    .rdata_o  (rom_rdata)
  );

  zbh_hasher u_hasher (
    .clk         (clk),
    .rst_n       (rst_n),
    .keys_done_i (keys_done),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .rom_raddr_o (rom_raddr),
    .rom_rdata_i (rom_rdata)
  );

  // No request is taken before the key table is complete
  a_ready_keys: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> keys_done)
    else $error("input ready before key table filled");

  // The key table is never written once it is complete
  a_no_late_write: assert property (@(posedge clk) disable iff (!rst_n)
    keys_done |-> !key_wr.en)
    else $error("key table written after fill");

  // Key writes stay inside the table
  a_key_addr: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr.en |-> (key_wr.addr < KEY_AW'(KEY_COUNT)))
    else $error("key write beyond table");

  // One item at a time: ready drops after an accepted request
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while busy");

endmodule

`default_nettype wire

// File: rtl/zbh_keygen.sv
//------------------------------------------------------------------------------
// zbh_keygen
// Fills the key table after reset with the first 781 outputs of a 64-bit
// Mersenne twister seeded with zero. One 32x32 multiplier serves the seeding
// recurrence, one partial product at a time; one state memory read port serves the twist.
//------------------------------------------------------------------------------
`default_nettype none

module zbh_keygen (
  input  logic            clk,
  input  logic            rst_n,
  output zbh_pkg::key_wr_t key_wr_o,
  output logic            keys_done_o
);
  import zbh_pkg::*;

  // Output tempering of one state word
  function automatic logic [63:0] temper(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ ((x >> 29) & MT_TMASK_A);
    x = x ^ ((x << 17) & MT_TMASK_B);
    x = x ^ ((x << 37) & MT_TMASK_C);
    x = x ^ (x >> 43);
    return x;
  endfunction

  kg_state_t         st_r, st_nxt;
  logic [MT_AW-1:0]  idx_r, idx_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [KEY_AW-1:0] kcnt_r, kcnt_nxt;
  logic [63:0]       prev_r, prev_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       a_r, a_nxt;
  logic [63:0]       b_r, b_nxt;
  logic [63:0]       prod_r;

  // State memory
  logic [63:0]       mt_mem [MT_N];
  logic [63:0]       rd_q;
  logic              mt_we;
  logic [MT_AW-1:0]  mt_waddr;
  logic [63:0]       mt_wdata;
  logic [MT_AW-1:0]  mt_raddr;

  // Shared multiplier operands
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;

  logic [63:0]       seed_x;
  logic [MT_AW-1:0]  nb1, nbm_sum, nbm;
  logic [63:0]       tw_y, tw_t, seed_val;
  logic              key_en;

  assign seed_x   = prev_r ^ (prev_r >> 62);
  assign mul_p    = mul_a * mul_b;
  assign seed_val = acc_r + {prod_r[31:0], 32'd0};

  // Twist neighbors, modulo the state length
  assign nb1     = (idx_r == MT_AW'(MT_N - 1)) ? '0 : idx_r + 1'b1;
  assign nbm_sum = idx_r + MT_AW'(MT_M);
  assign nbm     = (nbm_sum >= MT_AW'(MT_N)) ? nbm_sum - MT_AW'(MT_N) : nbm_sum;

  assign tw_y = (a_r & MT_UPPER) | (b_r & MT_LOWER);
  assign tw_t = (tw_y >> 1) ^ (tw_y[0] ? MT_MATRIX : 64'd0);

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    ph_nxt   = ph_r;
    kcnt_nxt = kcnt_r;
    prev_nxt = prev_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    mt_we    = 1'b0;
    mt_waddr = idx_r;
    mt_wdata = seed_val;
    mt_raddr = idx_r;
    mul_a    = seed_x[31:0];
    mul_b    = MT_MULT[31:0];
    key_en   = 1'b0;
    unique case (st_r)
      KG_SEED0: begin
        mt_we    = 1'b1;
        mt_waddr = '0;
        mt_wdata = 64'd0;
        prev_nxt = 64'd0;
        idx_nxt  = MT_AW'(1);
        ph_nxt   = 2'd0;
        st_nxt   = KG_SEED;
      end
      KG_SEED: begin
        ph_nxt = ph_r + 2'd1;
        unique case (ph_r)
          2'd0: begin
            mul_a = seed_x[31:0];
            mul_b = MT_MULT[31:0];
          end
          2'd1: begin
            acc_nxt = prod_r + 64'(idx_r);
            mul_a   = seed_x[63:32];
            mul_b   = MT_MULT[31:0];
          end
          2'd2: begin
            acc_nxt = seed_val;
            mul_a   = seed_x[31:0];
            mul_b   = MT_MULT[63:32];
          end
          2'd3: begin
            mt_we    = 1'b1;
            prev_nxt = seed_val;
            if (idx_r == MT_AW'(MT_N - 1)) begin
              idx_nxt = '0;
              st_nxt  = KG_TWIST;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        endcase
      end
      KG_TWIST: begin
        ph_nxt = ph_r + 2'd1;
        unique case (ph_r)
          2'd0: mt_raddr = idx_r;
          2'd1: begin
            a_nxt    = rd_q;
            mt_raddr = nb1;
          end
          2'd2: begin
            b_nxt    = rd_q;
            mt_raddr = nbm;
          end
          2'd3: begin
            mt_we    = 1'b1;
            mt_wdata = rd_q ^ tw_t;
            if (idx_r == MT_AW'(MT_N - 1)) begin
              idx_nxt = '0;
              st_nxt  = KG_GEN;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        endcase
      end
      KG_GEN: begin
        if (ph_r == 2'd0) begin
          mt_raddr = idx_r;
          ph_nxt   = 2'd1;
        end else begin
          key_en   = 1'b1;
          kcnt_nxt = kcnt_r + 1'b1;
          ph_nxt   = 2'd0;
          priority if (kcnt_r == KEY_AW'(KEY_COUNT - 1)) begin
            st_nxt = KG_DONE;
          end else if (idx_r == MT_AW'(MT_N - 1)) begin
            idx_nxt = '0;
            st_nxt  = KG_TWIST;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      KG_DONE: begin
        st_nxt = KG_DONE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= KG_SEED0;
      idx_r  <= '0;
      ph_r   <= 2'd0;
      kcnt_r <= '0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      ph_r   <= ph_nxt;
      kcnt_r <= kcnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    acc_r  <= acc_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= mul_p;
  end

  // State memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mt_we) begin
      mt_mem[mt_waddr] <= mt_wdata;
    end
    rd_q <= mt_mem[mt_raddr];
  end

  assign key_wr_o.en   = key_en;
  assign key_wr_o.addr = kcnt_r;
  assign key_wr_o.data = temper(rd_q);
  assign keys_done_o   = (st_r == KG_DONE);

endmodule

`default_nettype wire

// File: rtl/zbh_key_rom.sv
//------------------------------------------------------------------------------
// zbh_key_rom
// Key table: 781 words of 64 bits, written once by the generator after reset,
// read by the hash sequencer with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module zbh_key_rom (
  input  logic                      clk,
  input  zbh_pkg::key_wr_t          key_wr_i,
  input  logic [zbh_pkg::KEY_AW-1:0] raddr_i,
  output logic [63:0]               rdata_o
);
  import zbh_pkg::*;

  logic [63:0] mem [KEY_COUNT];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (key_wr_i.en) begin
      mem[key_wr_i.addr] <= key_wr_i.data;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

`default_nettype wire

// File: rtl/zbh_hasher.sv
//------------------------------------------------------------------------------
// zbh_hasher
// Hash sequencer: takes one position item, walks its set bits one per cycle
// (lowest first), reads the matching key and folds it into the accumulator.
//------------------------------------------------------------------------------
`default_nettype none

module zbh_hasher (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       keys_done_i,
  zbh_in_if.sink                     in_ch,
  zbh_out_if.source                  out_ch,
  output logic [zbh_pkg::KEY_AW-1:0] rom_raddr_o,
  input  logic [63:0]                rom_rdata_i
);
  import zbh_pkg::*;

  // Index of the single set bit of a one-hot word
  function automatic logic [5:0] onehot_idx(input logic [63:0] oh);
    logic [5:0] idx;
    idx = '0;
    for (int n = 0; n < 64; n++) begin
      if (oh[n]) idx = idx | 6'(n);
    end
    return idx;
  endfunction

  // Header slot to key address
  function automatic logic [KEY_AW-1:0] hdr_addr(input logic [2:0] slot,
                                                 input logic [2:0] epf);
    logic [KEY_AW-1:0] a;
    unique case (slot)
      HDR_WHITE: a = KEY_AW'(WHITE_KEY);
      HDR_EP:    a = KEY_AW'(EP_KEY) + KEY_AW'(epf);
      HDR_BK:    a = KEY_AW'(KSIDE_KEY);
      HDR_WK:    a = KEY_AW'(KSIDE_KEY + 1);
      HDR_BQ:    a = KEY_AW'(QSIDE_KEY);
      HDR_WQ:    a = KEY_AW'(QSIDE_KEY + 1);
      default:   a = KEY_AW'(WHITE_KEY);
    endcase
    return a;
  endfunction

  hs_state_t   st_r, st_nxt;
  logic [63:0] pend_r, pend_nxt;
  logic        hdr_r, hdr_nxt;
  logic [2:0]  epf_r, epf_nxt;
  logic [3:0]  base_r, base_nxt;
  logic        last_r, last_nxt;
  logic        rdv_r, rdv_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        ovld_r, ovld_nxt;
  logic [63:0] ohash_r, ohash_nxt;

  logic [63:0] lsb;
  logic [5:0]  sq;
  logic        in_take;

  // Lowest pending bit and its key address
  assign lsb         = pend_r & (~pend_r + 64'd1);
  assign sq          = onehot_idx(lsb);
  assign rom_raddr_o = hdr_r ? hdr_addr(sq[2:0], epf_r) : {base_r, sq};

  assign in_ch.ready = (st_r == HS_IDLE) && keys_done_i;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    st_nxt    = st_r;
    pend_nxt  = pend_r;
    hdr_nxt   = hdr_r;
    epf_nxt   = epf_r;
    base_nxt  = base_r;
    last_nxt  = last_r;
    rdv_nxt   = 1'b0;
    acc_nxt   = acc_r;
    ohash_nxt = ohash_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    unique case (st_r)
      HS_IDLE: begin
        if (in_take) begin
          hdr_nxt  = !in_ch.mode;
          epf_nxt  = in_ch.ep_square[2:0];
          base_nxt = in_ch.piece_color ? {1'b0, in_ch.piece_kind} + 4'(KIND_COUNT)
                                       : {1'b0, in_ch.piece_kind};
          last_nxt = in_ch.last;
          if (!in_ch.mode) begin
            acc_nxt  = 64'd0;
            pend_nxt = {58'd0, in_ch.castle_rights, in_ch.ep_valid,
                        in_ch.white_to_move};
          end else if (in_ch.piece_kind < 3'(KIND_COUNT)) begin
            pend_nxt = in_ch.piece_bitboard;
          end else begin
            pend_nxt = 64'd0;
          end
          st_nxt = HS_RUN;
        end
      end
      HS_RUN: begin
        // fold the key read last cycle
        if (rdv_r) begin
          acc_nxt = acc_r ^ rom_rdata_i;
        end
        // issue the next key read
        if (pend_r != 64'd0) begin
          pend_nxt = pend_r & ~lsb;
          rdv_nxt  = 1'b1;
        end
        // item complete; a hash waits for a free output slot
        if ((pend_r == 64'd0) && !rdv_r) begin
          if (!last_r) begin
            st_nxt = HS_IDLE;
          end else if (!ovld_r || out_ch.ready) begin
            ovld_nxt  = 1'b1;
            ohash_nxt = acc_r;
            st_nxt    = HS_IDLE;
          end
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= HS_IDLE;
      rdv_r  <= 1'b0;
      ovld_r <= 1'b0;
      acc_r  <= 64'd0;
      pend_r <= 64'd0;
    end else begin
      st_r   <= st_nxt;
      rdv_r  <= rdv_nxt;
      ovld_r <= ovld_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    hdr_r   <= hdr_nxt;
    epf_r   <= epf_nxt;
    base_r  <= base_nxt;
    last_r  <= last_nxt;
    ohash_r <= ohash_nxt;
  end

  assign out_ch.valid      = ovld_r;
  assign out_ch.hash_value = ohash_r;

endmodule

`default_nettype wire
